// ===== hw/rtl/rha_pkg.sv =====
// ----------------------------------------------------------------------------
// rha_pkg
// Shared types and constants of the rectangular assignment solver.
// ----------------------------------------------------------------------------
package rha_pkg;

    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_COST_BITS   = 24;
    localparam int MAX_RESULTS     = 16;

    localparam int INDEX_BITS     = 4;
    localparam int IN_COST_BITS   = 24;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 4'd1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_SOLVE_INIT,
        DP_ROW_START,
        DP_STEP_START,
        DP_SCAN,
        DP_UPDATE,
        DP_AUGMENT,
        DP_ROW_NEXT,
        DP_COLLECT,
        DP_EMIT,
        DP_FAIL
    } dp_op_t;

    typedef struct packed {
        logic cnt_last;
        logic found;
        logic c0_free;
        logic path_end;
        logic row_last;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/rha_if.sv =====
// ----------------------------------------------------------------------------
// rha_if
// Channel interfaces: matrix entries, results and register writes.
// ----------------------------------------------------------------------------
interface rha_in_if;
    logic                               valid;
    logic                               ready;
    logic [rha_pkg::INDEX_BITS-1:0]     row_index;
    logic [rha_pkg::INDEX_BITS-1:0]     column_index;
    logic [rha_pkg::IN_COST_BITS-1:0]   entry_cost;
    logic                               is_forbidden;
    logic                               load_done;

    modport source (output valid, row_index, column_index, entry_cost, is_forbidden,
                    load_done, input ready);
    modport sink   (input valid, row_index, column_index, entry_cost, is_forbidden,
                    load_done, output ready);
endinterface

interface rha_out_if;
    logic                           valid;
    logic                           ready;
    logic [rha_pkg::INDEX_BITS-1:0] result_row;
    logic [rha_pkg::INDEX_BITS-1:0] assigned_column;
    logic                           status;
    logic                           last_result;

    modport source (output valid, result_row, assigned_column, status, last_result,
                    input ready);
    modport sink   (input valid, result_row, assigned_column, status, last_result,
                    output ready);
endinterface

interface rha_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rha_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rha_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rectangular_hungarian_assignment.sv =====
// ----------------------------------------------------------------------------
// rectangular_hungarian_assignment
// Minimum-cost row-to-column assignment (potential-based Hungarian method).
// ----------------------------------------------------------------------------
// Matrix entries load at one beat per cycle while the solver is idle; the
// beat with load_done starts the solve and entry is held off until the last
// result of the run sits in the output register. Each augmenting step sweeps
// the columns twice, one column per cycle: a scan through the single read port
// of the cost RAM and an update of potentials and slacks. A row takes at most
// column_count steps, then a path reversal. Results then leave at one beat per
// cycle while result.ready stays high; a failed run gives one beat. Register
// writes are always taken.
module rectangular_hungarian_assignment #(
    parameter int MAX_ROWS    = rha_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = rha_pkg::DEF_MAX_COLUMNS,
    parameter int COST_BITS   = rha_pkg::DEF_COST_BITS
) (
    input  logic clk,
    input  logic rst_n,
    rha_in_if.sink    entry,
    rha_out_if.source result,
    rha_cfg_if.sink   cfg
);
    import rha_pkg::*;

    dp_op_t     op;
    dp_status_t stat;
    logic       idle;
    logic       entry_fire;

    assign entry.ready = idle;
    assign cfg.ready   = 1'b1;
    assign entry_fire  = entry.valid && entry.ready;

    rha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (entry_fire && entry.load_done),
        .stat  (stat),
        .op    (op),
        .idle  (idle)
    );

    rha_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COST_BITS   (COST_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .stat       (stat),
        .wr_en      (entry_fire),
        .wr_row     (entry.row_index),
        .wr_col     (entry.column_index),
        .wr_cost    (entry.entry_cost),
        .wr_forbid  (entry.is_forbidden),
        .cfg_en     (cfg.valid && cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_row    (result.result_row),
        .out_column (result.assigned_column),
        .out_status (result.status),
        .out_last   (result.last_result)
    );

endmodule

// ===== hw/rtl/rha_ram.sv =====
// ----------------------------------------------------------------------------
// rha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== hw/rtl/rha_datapath.sv =====
// ----------------------------------------------------------------------------
// rha_datapath
// Cost RAM, potentials, slack, owner and path arrays, column sweep counter
// and result register of the assignment solver.
// ----------------------------------------------------------------------------
module rha_datapath #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int COST_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rha_pkg::dp_op_t                     op,
    output rha_pkg::dp_status_t                 stat,
    input  logic                                wr_en,
    input  logic [rha_pkg::INDEX_BITS-1:0]      wr_row,
    input  logic [rha_pkg::INDEX_BITS-1:0]      wr_col,
    input  logic [rha_pkg::IN_COST_BITS-1:0]    wr_cost,
    input  logic                                wr_forbid,
    input  logic                                cfg_en,
    input  logic [rha_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rha_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rha_pkg::INDEX_BITS-1:0]      out_row,
    output logic [rha_pkg::INDEX_BITS-1:0]      out_column,
    output logic                                out_status,
    output logic                                out_last
);
    import rha_pkg::*;

    localparam int ROW_LIM = (MAX_ROWS < MAX_RESULTS) ? MAX_ROWS : MAX_RESULTS;
    localparam int RW      = $clog2(ROW_LIM + 1);
    localparam int CW      = $clog2(MAX_COLUMNS + 1);
    localparam int CIW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int OW      = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
    localparam int PW      = COST_BITS + 8;
    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW      = COST_BITS + 1;

    logic [RW-1:0]        rows_reg;
    logic [CW-1:0]        cols_reg;

    logic signed [PW-1:0] row_pot_reg [0:ROW_LIM];
    logic signed [PW-1:0] col_pot_reg [0:MAX_COLUMNS];
    logic signed [PW-1:0] slack_reg   [0:MAX_COLUMNS];
    logic [RW-1:0]        owner_reg   [0:MAX_COLUMNS];
    logic [CW-1:0]        path_reg    [0:MAX_COLUMNS];
    logic [CIW-1:0]       assign_reg  [0:ROW_LIM-1];
    logic [MAX_COLUMNS:0] valid_reg;
    logic [MAX_COLUMNS:0] visited_reg;

    logic [CW-1:0]        c0_reg;
    logic [CW-1:0]        c1_reg;
    logic [CW-1:0]        cnt_reg;
    logic [RW-1:0]        r0_reg;
    logic [RW-1:0]        row_reg;
    logic [OW-1:0]        oc_reg;
    logic signed [PW-1:0] rp_reg;
    logic signed [PW-1:0] delta_reg;
    logic                 found_reg;

    logic                 out_valid_reg;
    logic [INDEX_BITS-1:0] out_row_reg;
    logic [INDEX_BITS-1:0] out_column_reg;
    logic                 out_status_reg;
    logic                 out_last_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    logic [RW-1:0]        rd_row;
    logic [CW-1:0]        rd_col;

    logic signed [PW-1:0] cost_ext;
    logic signed [PW-1:0] cur;
    logic                 take;
    logic                 eff_valid;
    logic signed [PW-1:0] eff_slack;
    logic                 better;
    logic                 emit_last;
    logic                 out_free;

    function automatic logic [CW-1:0] clamp_count(input logic [CFG_DATA_BITS-1:0] v,
                                                  input int hi);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (int'(v) > hi)
        begin
            r = CW'(hi);
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    // cost RAM
    assign ram_we    = wr_en && (int'(wr_row) < MAX_ROWS) && (int'(wr_col) < MAX_COLUMNS);
    assign ram_waddr = AW'(int'(wr_row) * MAX_COLUMNS + int'(wr_col));
    assign ram_wdata = {wr_forbid, COST_BITS'(wr_cost)};

    assign rd_row    = (op == DP_STEP_START) ? owner_reg[c0_reg] : r0_reg;
    assign rd_col    = (op == DP_STEP_START) ? CW'(1) : CW'(cnt_reg + 1'b1);
    assign ram_raddr = AW'((int'(rd_row) - 1) * MAX_COLUMNS + int'(rd_col) - 1);

    rha_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // slack evaluation of the swept column
    always_comb
    begin
        cost_ext  = $signed({{(PW-COST_BITS){1'b0}}, ram_rdata[COST_BITS-1:0]});
        cur       = cost_ext - rp_reg - col_pot_reg[cnt_reg];
        take      = !visited_reg[cnt_reg] && !ram_rdata[COST_BITS]
                    && (!valid_reg[cnt_reg] || (cur < slack_reg[cnt_reg]));
        eff_valid = valid_reg[cnt_reg] || take;
        eff_slack = take ? cur : slack_reg[cnt_reg];
        better    = !visited_reg[cnt_reg] && eff_valid
                    && (!found_reg || (eff_slack < delta_reg));
    end

    assign emit_last = (int'(oc_reg) + 1) == int'(rows_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.cnt_last  = (cnt_reg == cols_reg);
    assign stat.found     = found_reg;
    assign stat.c0_free   = (owner_reg[c0_reg] == '0);
    assign stat.path_end  = (path_reg[c0_reg] == '0);
    assign stat.row_last  = (row_reg == rows_reg);
    assign stat.emit_last = emit_last;
    assign stat.out_free  = out_free;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= RW'(1);
            cols_reg      <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                priority case (cfg_index)
                    REG_ROW_COUNT:    rows_reg <= RW'(clamp_count(cfg_data, ROW_LIM));
                    REG_COLUMN_COUNT: cols_reg <= clamp_count(cfg_data, MAX_COLUMNS);
                    default:          ;
                endcase
            end
            if (op == DP_EMIT || op == DP_FAIL)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // solver state
    always_ff @(posedge clk)
    begin
        unique case (op)
            DP_SOLVE_INIT:
            begin
                for (int i = 0; i <= ROW_LIM; i++)
                begin
                    row_pot_reg[i] <= '0;
                end
                for (int i = 0; i <= MAX_COLUMNS; i++)
                begin
                    col_pot_reg[i] <= '0;
                    owner_reg[i]   <= '0;
                    path_reg[i]    <= '0;
                end
                for (int i = 0; i < ROW_LIM; i++)
                begin
                    assign_reg[i] <= '0;
                end
                row_reg <= RW'(1);
            end
            DP_ROW_START:
            begin
                owner_reg[0] <= row_reg;
                valid_reg    <= '0;
                visited_reg  <= '0;
                c0_reg       <= '0;
            end
            DP_STEP_START:
            begin
                visited_reg[c0_reg] <= 1'b1;
                r0_reg              <= owner_reg[c0_reg];
                rp_reg              <= row_pot_reg[owner_reg[c0_reg]];
                found_reg           <= 1'b0;
                delta_reg           <= '0;
                cnt_reg             <= CW'(1);
            end
            DP_SCAN:
            begin
                if (take)
                begin
                    slack_reg[cnt_reg] <= cur;
                    valid_reg[cnt_reg] <= 1'b1;
                    path_reg[cnt_reg]  <= c0_reg;
                end
                if (better)
                begin
                    delta_reg <= eff_slack;
                    c1_reg    <= cnt_reg;
                    found_reg <= 1'b1;
                end
                cnt_reg <= (cnt_reg == cols_reg) ? '0 : CW'(cnt_reg + 1'b1);
            end
            DP_UPDATE:
            begin
                if (visited_reg[cnt_reg])
                begin
                    row_pot_reg[owner_reg[cnt_reg]] <= row_pot_reg[owner_reg[cnt_reg]]
                                                       + delta_reg;
                    col_pot_reg[cnt_reg] <= col_pot_reg[cnt_reg] - delta_reg;
                end
                else if (valid_reg[cnt_reg])
                begin
                    slack_reg[cnt_reg] <= slack_reg[cnt_reg] - delta_reg;
                end
                if (cnt_reg == cols_reg)
                begin
                    c0_reg <= c1_reg;
                end
                else
                begin
                    cnt_reg <= CW'(cnt_reg + 1'b1);
                end
            end
            DP_AUGMENT:
            begin
                owner_reg[c0_reg] <= owner_reg[path_reg[c0_reg]];
                c0_reg            <= path_reg[c0_reg];
                cnt_reg           <= CW'(1);
            end
            DP_ROW_NEXT:
            begin
                row_reg <= RW'(row_reg + 1'b1);
            end
            DP_COLLECT:
            begin
                if (owner_reg[cnt_reg] != '0)
                begin
                    assign_reg[OW'(owner_reg[cnt_reg] - 1'b1)] <= CIW'(cnt_reg - 1'b1);
                end
                cnt_reg <= CW'(cnt_reg + 1'b1);
                oc_reg  <= '0;
            end
            DP_EMIT:
            begin
                out_row_reg    <= INDEX_BITS'(oc_reg);
                out_column_reg <= INDEX_BITS'(assign_reg[oc_reg]);
                out_status_reg <= STATUS_OK;
                out_last_reg   <= emit_last;
                oc_reg         <= OW'(oc_reg + 1'b1);
            end
            DP_FAIL:
            begin
                out_row_reg    <= INDEX_BITS'(row_reg - 1'b1);
                out_column_reg <= '0;
                out_status_reg <= STATUS_FAIL;
                out_last_reg   <= 1'b1;
            end
            DP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_column = out_column_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== hw/rtl/rha_ctrl.sv =====
// ----------------------------------------------------------------------------
// rha_ctrl
// Sequencer of the solve: row loop, augmenting steps, column sweeps, output.
// ----------------------------------------------------------------------------
module rha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rha_pkg::dp_status_t stat,
    output rha_pkg::dp_op_t     op,
    output logic                idle
);
    import rha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_STEP,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_CHECK,
        S_AUGMENT,
        S_ROW_NEXT,
        S_COLLECT,
        S_EMIT,
        S_FAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                op         = DP_SOLVE_INIT;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                op         = DP_ROW_START;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                op         = DP_STEP_START;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                op = DP_SCAN;
                if (stat.cnt_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = stat.found ? S_UPDATE : S_FAIL;
            end
            S_UPDATE:
            begin
                op = DP_UPDATE;
                if (stat.cnt_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.c0_free ? S_AUGMENT : S_STEP;
            end
            S_AUGMENT:
            begin
                op = DP_AUGMENT;
                if (stat.path_end)
                begin
                    state_next = stat.row_last ? S_COLLECT : S_ROW_NEXT;
                end
            end
            S_ROW_NEXT:
            begin
                op         = DP_ROW_NEXT;
                state_next = S_ROW;
            end
            S_COLLECT:
            begin
                op = DP_COLLECT;
                if (stat.cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    op = DP_EMIT;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FAIL:
            begin
                if (stat.out_free)
                begin
                    op         = DP_FAIL;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule
